/* sv/pbp_pkg.sv */
// ----------------------------------------------------------------------------
// pbp_pkg
// Shared types and fixed constants of the perceptron branch predictor.
// ----------------------------------------------------------------------------
package pbp_pkg;

   localparam int WEIGHT_W   = 9;   // signed weight, clamped to +/- theta
   localparam int SUM_W      = 16;  // signed perceptron output
   localparam int THETA_W    = 8;
   localparam int ADDR_W     = 64;
   localparam int GROUP_SIZE = 8;   // terms added per partial sum

   localparam logic [THETA_W-1:0] THETA_RESET = 8'd44;

   typedef struct packed {
      logic [ADDR_W-1:0] branch_address;
      logic              actual_taken;
   } req_type;

   typedef struct packed {
      logic                    predicted_taken;
      logic signed [SUM_W-1:0] perceptron_sum;
      logic                    mispredicted;
      logic                    trained;
   } rsp_type;

   // enables of the two registered levels of the dot-product tree
   typedef struct packed {
      logic part_en;
      logic sum_en;
   } dot_ctl_type;

endpackage

/* sv/pbp_ram.sv */
// ----------------------------------------------------------------------------
// pbp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/pbp_dot.sv */
// ----------------------------------------------------------------------------
// pbp_dot
// Two-level registered adder tree: signed weights times +/-1 history bits.
// ----------------------------------------------------------------------------
module pbp_dot #(
   parameter int HIST_LEN = 16
) (
   input  logic                                      clock,
   input  pbp_pkg::dot_ctl_type                      ctl,
   input  logic [(HIST_LEN+1)*pbp_pkg::WEIGHT_W-1:0] row_data,
   input  logic [HIST_LEN-1:0]                       hist,
   output logic signed [pbp_pkg::SUM_W-1:0]          y
);
   import pbp_pkg::*;

   localparam int ROW_W      = HIST_LEN + 1;
   localparam int NUM_GROUPS = (ROW_W + GROUP_SIZE - 1) / GROUP_SIZE;

   logic signed [SUM_W-1:0] term     [ROW_W];
   logic signed [SUM_W-1:0] part_in  [NUM_GROUPS];
   logic signed [SUM_W-1:0] part_ff  [NUM_GROUPS];
   logic signed [SUM_W-1:0] y_in;
   logic signed [SUM_W-1:0] y_ff;

   // sign-extend each weight; history bit 0 counts as -1
   for (genvar i = 0; i < ROW_W; i++) begin : g_term
      logic signed [SUM_W-1:0] ext;
      assign ext = {{(SUM_W-WEIGHT_W){row_data[i*WEIGHT_W+WEIGHT_W-1]}},
                    row_data[i*WEIGHT_W +: WEIGHT_W]};
      if (i == 0) begin : g_bias
         assign term[i] = ext;
      end else begin : g_hist
         assign term[i] = hist[i-1] ? ext : -ext;
      end
   end

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         part_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g*GROUP_SIZE + k < ROW_W) begin
               part_in[g] = part_in[g] + term[g*GROUP_SIZE + k];
            end
         end
      end
   end

   always_comb begin
      y_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         y_in = y_in + part_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.part_en) begin
         part_ff <= part_in;
      end
      if (ctl.sum_en) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

/* sv/pbp_train.sv */
// ----------------------------------------------------------------------------
// pbp_train
// Prediction, training decision and clamped weight update of one row.
// ----------------------------------------------------------------------------
module pbp_train #(
   parameter int HIST_LEN = 16
) (
   input  logic [(HIST_LEN+1)*pbp_pkg::WEIGHT_W-1:0] row_data,
   input  logic [HIST_LEN-1:0]                       hist,
   input  logic                                      taken,
   input  logic signed [pbp_pkg::SUM_W-1:0]          y,
   input  logic [pbp_pkg::THETA_W-1:0]               theta,
   output logic [(HIST_LEN+1)*pbp_pkg::WEIGHT_W-1:0] new_row,
   output pbp_pkg::rsp_type                          result
);
   import pbp_pkg::*;

   localparam int ROW_W = HIST_LEN + 1;
   localparam int CW    = WEIGHT_W + 1;

   logic                    pred;
   logic                    mis;
   logic [SUM_W-1:0]        abs_y;
   logic signed [CW-1:0]    theta_pos;
   logic signed [CW-1:0]    theta_neg;

   assign pred      = !y[SUM_W-1] && (y != '0);
   assign mis       = pred != taken;
   assign abs_y     = y[SUM_W-1] ? SUM_W'(-y) : SUM_W'(y);
   assign theta_pos = signed'({{(CW-THETA_W){1'b0}}, theta});
   assign theta_neg = -theta_pos;

   // step each weight toward agreement with the outcome, then clamp
   for (genvar i = 0; i < ROW_W; i++) begin : g_upd
      logic                 xbit;
      logic signed [CW-1:0] v;
      if (i == 0) begin : g_bias
         assign xbit = 1'b1;
      end else begin : g_hist
         assign xbit = hist[i-1];
      end
      assign v = signed'({row_data[i*WEIGHT_W+WEIGHT_W-1],
                          row_data[i*WEIGHT_W +: WEIGHT_W]})
               + ((taken == xbit) ? CW'(1) : -CW'(1));
      always_comb begin
         if (v > theta_pos) begin
            new_row[i*WEIGHT_W +: WEIGHT_W] = theta_pos[WEIGHT_W-1:0];
         end else if (v < theta_neg) begin
            new_row[i*WEIGHT_W +: WEIGHT_W] = theta_neg[WEIGHT_W-1:0];
         end else begin
            new_row[i*WEIGHT_W +: WEIGHT_W] = v[WEIGHT_W-1:0];
         end
      end
   end

   assign result.predicted_taken = pred;
   assign result.perceptron_sum  = y;
   assign result.mispredicted    = mis;
   assign result.trained         = mis || (abs_y < {{(SUM_W-THETA_W){1'b0}}, theta});

endmodule

/* sv/perceptron_branch_predictor.sv */
// ----------------------------------------------------------------------------
// perceptron_branch_predictor
// Global-history perceptron predictor, trained by resolved branches.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per resolved branch (address, actual outcome).
//   rsp channel: one beat per request with the prediction made from the
//   state before the update, the perceptron output, the mispredict flag and
//   whether the row was trained.
//   csr port: write theta (training margin and weight clamp) while idle.
// Sequence:
//   A request is taken in the idle state and reads its weight row from the
//   row RAM. Each request then passes RAM read, partial sums, final sum and
//   write-back of the trained row, where its result is registered; a new
//   request is taken only once the block is back in the idle state. The
//   read-modify-write of one row per branch is why requests do not overlap.
// Reset:
//   Clears history and control, returns theta to 44, then sweeps the row RAM
//   to zero, one row per cycle, through all 2**TABLE_BITS rows; req_stall
//   stays high meanwhile.
// Stall:
//   The result waits in the output register; the write-back step holds until
//   the register is free, so nothing is lost when rsp_stall is high.
// ----------------------------------------------------------------------------
module perceptron_branch_predictor #(
   parameter int TABLE_BITS = 10,
   parameter int HIST_LEN   = 16,
   parameter int PC_SHIFT   = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pbp_pkg::req_type              req_data,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pbp_pkg::rsp_type              rsp_data,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [pbp_pkg::THETA_W-1:0]   csr_wr_data
);
   import pbp_pkg::*;

   localparam int ROW_W   = HIST_LEN + 1;
   localparam int ROW_BITS = ROW_W * WEIGHT_W;
   localparam int DEPTH   = 1 << TABLE_BITS;

   // controller states
   localparam logic [2:0] S_CLEAR = 3'd0;  // zero sweep after reset
   localparam logic [2:0] S_IDLE  = 3'd1;  // wait for a request beat
   localparam logic [2:0] S_PART  = 3'd2;  // row data out of RAM
   localparam logic [2:0] S_SUM   = 3'd3;  // partial sums registered
   localparam logic [2:0] S_WRB   = 3'd4;  // write back, emit result

   logic [2:0]            state_ff, state_in;
   logic [TABLE_BITS-1:0] clr_ff, clr_in;
   logic [THETA_W-1:0]    theta_ff, theta_in;
   logic [HIST_LEN-1:0]   history_ff, history_in;
   logic [HIST_LEN:0]     history_ext;
   logic [HIST_LEN-1:0]   hist_use_ff;
   logic                  taken_ff;
   logic [TABLE_BITS-1:0] row_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff;

   logic                  req_accept;
   logic                  rsp_load;
   logic                  mem_we;
   logic [TABLE_BITS-1:0] mem_waddr;
   logic [ROW_BITS-1:0]   mem_wdata;
   logic [ROW_BITS-1:0]   mem_rdata;
   logic [TABLE_BITS-1:0] req_row;
   logic signed [SUM_W-1:0] y;
   logic [ROW_BITS-1:0]   new_row;
   rsp_type               result;
   dot_ctl_type           dot_ctl;

   // row index: address bits just above the shift
   assign req_row     = req_data.branch_address[PC_SHIFT +: TABLE_BITS];
   assign req_stall   = (state_ff != S_IDLE);
   assign req_accept  = req_valid && !req_stall;
   // load the output register when it is empty or being drained this cycle
   assign rsp_load    = (state_ff == S_WRB) && (!rsp_valid_ff || !rsp_stall);

   // shift the outcome into the history, drop the oldest bit
   assign history_ext = {history_ff, req_data.actual_taken};

   assign dot_ctl.part_en = (state_ff == S_PART);
   assign dot_ctl.sum_en  = (state_ff == S_SUM);

   // write port: zero sweep, or trained row at write-back
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = row_ff;
      mem_wdata = new_row;
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (rsp_load && result.trained) begin
         mem_we    = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      history_in   = history_ff;
      theta_in     = csr_wr_en ? csr_wr_data : theta_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + TABLE_BITS'(1);
            if (clr_ff == {TABLE_BITS{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               history_in = history_ext[HIST_LEN-1:0];
               state_in   = S_PART;
            end
         end
         S_PART: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_WRB;
         end
         S_WRB: begin
            // hold here until the output register can take the beat
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         theta_ff     <= THETA_RESET;
         history_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         theta_ff     <= theta_in;
         history_ff   <= history_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload of the request in flight, and the result beat
   always_ff @(posedge clock) begin
      if (req_accept) begin
         hist_use_ff <= history_ff;
         taken_ff    <= req_data.actual_taken;
         row_ff      <= req_row;
      end
      if (rsp_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   pbp_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (DEPTH)
   ) u_rows (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (req_accept),
      .rd_addr (req_row),
      .rd_data (mem_rdata)
   );

   pbp_dot #(
      .HIST_LEN (HIST_LEN)
   ) u_dot (
      .clock    (clock),
      .ctl      (dot_ctl),
      .row_data (mem_rdata),
      .hist     (hist_use_ff),
      .y        (y)
   );

   pbp_train #(
      .HIST_LEN (HIST_LEN)
   ) u_train (
      .row_data (mem_rdata),
      .hist     (hist_use_ff),
      .taken    (taken_ff),
      .y        (y),
      .theta    (theta_ff),
      .new_row  (new_row),
      .result   (result)
   );

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> req_stall)
      else $error("request accepted during the RAM clear sweep");

   a_write_only_clear_or_wrb: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_WRB))
      else $error("row RAM written outside clear or write-back");

   a_rsp_from_wrb: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_WRB))
      else $error("result beat raised without a write-back step");

   a_mispredict_trains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.mispredicted) |-> rsp_data.trained)
      else $error("mispredicted branch did not train its row");

   a_history_takes_outcome: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (history_ff[0] == $past(req_data.actual_taken)))
      else $error("history did not shift in the outcome");
`endif

endmodule

/* tb/perceptron_branch_predictor_tb.sv */
// ----------------------------------------------------------------------------
// perceptron_branch_predictor_tb
// Self-checking bench for the global-history perceptron branch predictor.
// Streams resolved branches through the request channel, predicts each
// result with its own copy of weights, history and theta, and compares every
// result beat field by field. Theta is stepped through its extremes between
// phases; both sides idle at random and the receiver holds off once for a
// long stretch so the block backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module perceptron_branch_predictor_tb;
   import pbp_pkg::*;

   localparam int TABLE_BITS = 10;
   localparam int HIST_LEN   = 16;
   localparam int PC_SHIFT   = 2;
   localparam int ROWS       = 1 << TABLE_BITS;
   localparam int ROW_TERMS  = HIST_LEN + 1;   // bias plus one weight per history bit
   localparam int PHASES     = 6;
   localparam int PHASE_LEN  = 320;
   localparam int HOT_ROWS   = 6;
   localparam int LONG_HOLD  = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_type              req_data    = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en   = 1'b0;
   logic [THETA_W-1:0]   csr_wr_data = '0;

   // branches waiting to go out; the head is the beat on the bus
   req_type branch_queue [$];
   // predicted result beats, oldest first
   rsp_type expected_results [$];

   // predictor state
   int                  row_weights [ROWS][ROW_TERMS];
   logic [HIST_LEN-1:0] path_history;
   logic [THETA_W-1:0]  clamp_theta;

   // idle rates in percent, and the long receiver hold-off
   int send_idle_pct  = 37;
   int recv_idle_pct  = 86;
   int long_hold_len  = 0;
   int held_cycles    = 0;

   int      error_count = 0;
   bit      offer_next;
   rsp_type got_beat;
   rsp_type want_beat;

   // pattern generators for the hot rows
   int hot_row    [HOT_ROWS];
   int trip_count [HOT_ROWS];

   perceptron_branch_predictor #(
      .TABLE_BITS (TABLE_BITS),
      .HIST_LEN   (HIST_LEN),
      .PC_SHIFT   (PC_SHIFT)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Resolve one branch against the predictor state: form y from the row
   // selected by the address, train the row when wrong or not confident,
   // clamp with the current theta, then shift the outcome into the history.
   task automatic resolve_branch(input req_type br);
      int      row;
      int      y;
      int      mag;
      int      dir;
      int      x;
      int      w;
      int      th;
      logic    pred;
      logic    miss;
      logic    train;
      rsp_type beat;
      row = int'(br.branch_address[PC_SHIFT +: TABLE_BITS]);
      th  = int'(clamp_theta);
      y   = row_weights[row][0];
      for (int i = 0; i < HIST_LEN; i++) begin
         if (path_history[i])
            y += row_weights[row][i+1];
         else
            y -= row_weights[row][i+1];
      end
      pred  = (y > 0);
      miss  = (pred != br.actual_taken);
      mag   = (y < 0) ? -y : y;
      train = miss || (mag < th);
      if (train) begin
         dir = br.actual_taken ? 1 : -1;
         for (int i = 0; i < ROW_TERMS; i++) begin
            if (i == 0)
               x = 1;
            else
               x = path_history[i-1] ? 1 : -1;
            w = row_weights[row][i] + dir * x;
            // signed symmetric clamp to +/- theta
            if (w > th)
               w = th;
            else if (w < -th)
               w = -th;
            row_weights[row][i] = w;
         end
      end
      path_history = {path_history[HIST_LEN-2:0], br.actual_taken};
      beat.predicted_taken = pred;
      beat.perceptron_sum  = y[SUM_W-1:0];
      beat.mispredicted    = miss;
      beat.trained         = train;
      expected_results.push_back(beat);
   endtask

   task automatic queue_branch(input logic [ADDR_W-1:0] addr, input logic taken);
      req_type br;
      br.branch_address = addr;
      br.actual_taken   = taken;
      branch_queue.push_back(br);
   endtask

   // Mostly well-formed traffic: a few hot rows with loop-like outcome
   // patterns so weights build up, saturate and hit the clamp. The rest is
   // random addresses and outcomes. Bits outside the row index stay random.
   task automatic queue_random_phase(input int count);
      logic [ADDR_W-1:0] addr;
      logic              taken;
      int                k;
      for (int i = 0; i < HOT_ROWS; i++) begin
         hot_row[i]    = $urandom_range(ROWS - 1);
         trip_count[i] = 0;
      end
      for (int n = 0; n < count; n++) begin
         addr = {$urandom, $urandom};
         if ($urandom_range(99) < 75) begin
            k = $urandom_range(HOT_ROWS - 1);
            addr[PC_SHIFT +: TABLE_BITS] = TABLE_BITS'(hot_row[k]);
            if (k == 0)
               taken = 1'b1;
            else if (k == 1)
               taken = 1'b0;
            else
               taken = (trip_count[k] % (k + 1)) != 0;
            trip_count[k]++;
            // occasional noise breaks the pattern
            if ($urandom_range(99) < 8)
               taken = ~taken;
         end else begin
            taken = 1'($urandom_range(1));
         end
         queue_branch(addr, taken);
      end
   endtask

   // Driver: hold the beat until accepted, then advance to the next pending
   // branch or drop valid to idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            resolve_branch(branch_queue.pop_front());
            offer_next = 1'b1;
         end else begin
            offer_next = !req_valid;
         end
         if (offer_next) begin
            if (branch_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= branch_queue[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: a long hold-off first when one is requested, random stall
   // otherwise.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (held_cycles < long_hold_len) begin
         rsp_stall   <= 1'b1;
         held_cycles <= held_cycles + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Monitor: compare every accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_beat = rsp_data;
         if (expected_results.size() == 0) begin
            $error("result beat with no branch outstanding");
            error_count++;
         end else begin
            want_beat = expected_results.pop_front();
            if (got_beat.predicted_taken !== want_beat.predicted_taken) begin
               $error("predicted_taken: expected %0d, actual %0d",
                      want_beat.predicted_taken, got_beat.predicted_taken);
               error_count++;
            end
            if (got_beat.perceptron_sum !== want_beat.perceptron_sum) begin
               $error("perceptron_sum: expected %0d, actual %0d",
                      want_beat.perceptron_sum, got_beat.perceptron_sum);
               error_count++;
            end
            if (got_beat.mispredicted !== want_beat.mispredicted) begin
               $error("mispredicted: expected %0d, actual %0d",
                      want_beat.mispredicted, got_beat.mispredicted);
               error_count++;
            end
            if (got_beat.trained !== want_beat.trained) begin
               $error("trained: expected %0d, actual %0d",
                      want_beat.trained, got_beat.trained);
               error_count++;
            end
         end
      end
   end

   // Main sequence: reset, directed branches at the reset theta, then one
   // random phase per theta setting with the idle mix changing as it goes.
   initial begin
      logic [THETA_W-1:0] phase_theta [PHASES];
      for (int r = 0; r < ROWS; r++)
         for (int i = 0; i < ROW_TERMS; i++)
            row_weights[r][i] = 0;
      path_history = '0;
      clamp_theta  = THETA_RESET;

      phase_theta[0] = 8'd255;
      phase_theta[1] = 8'd3;    // well below 255: saturated weights stay out of bound
      phase_theta[2] = 8'd0;    // every trained weight clamps to zero
      phase_theta[3] = 8'd1;
      phase_theta[4] = THETA_W'($urandom_range(4, 254));
      phase_theta[5] = THETA_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: address extremes, bits outside the index ignored, both
      // outcomes, a row trained until it predicts taken, then wrong.
      queue_branch(64'h0, 1'b1);
      queue_branch({ADDR_W{1'b1}}, 1'b0);
      queue_branch(64'h3, 1'b1);
      queue_branch(64'hFFFF_FFFF_FFFF_F000, 1'b1);
      queue_branch(64'h0000_0000_0000_0FFF, 1'b1);
      queue_branch(64'hFFFF_FFFF_FFFF_FFFC, 1'b0);
      queue_branch(64'h5555_5555_5555_5555, 1'b1);
      queue_branch(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      repeat (8) queue_branch(64'h14, 1'b1);
      queue_branch(64'h8000_0000_0000_0014, 1'b0);
      queue_branch(64'h17, 1'b0);
      queue_branch(64'h14, 1'b1);
      queue_branch(64'h0, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         // drain, then let the last write-back finish before touching theta
         while (branch_queue.size() != 0 || expected_results.size() != 0)
            @(negedge clock);
         repeat (8) @(negedge clock);
         @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= phase_theta[p];
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         clamp_theta = phase_theta[p];
         @(negedge clock);

         if (p < 2) begin
            send_idle_pct = 37;
            recv_idle_pct = 86;
         end else if (p < 4) begin
            send_idle_pct = 86;
            recv_idle_pct = 37;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // back the block up once while the sender keeps offering
         if (p == 4)
            long_hold_len = LONG_HOLD;
         queue_random_phase(PHASE_LEN);
      end

      while (branch_queue.size() != 0 || expected_results.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);

      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, reset sweep included.
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
